FILE: rtl/wtd_pkg.sv
// Package for the waypoint to turn/drive converter.
// Holds widths, register indexes, saturation limits and the arctangent table.
// No dependencies.
package wtd_pkg;

  localparam int COORD_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // Square root unit: radicand below 2^51, root of 26 bits.
  localparam int SQ_W   = 52;
  localparam int ROOT_W = 26;

  // Shared multiplier operands and product.
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIST_W = 25;
  localparam logic [DIST_W-1:0] MAX25 = '1;

  localparam int ATAN_LEN = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_DUR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MS_PER_CM     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DUR      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WAYPOINTS = 3'd7;

  // Result kinds.
  localparam logic KIND_TURN    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Input commands.
  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_WAYPOINT = 1'b1;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/wtd_in_if.sv
// Input channel interface: one waypoint or start word per handshake.
// Depends on nothing; width follows the coordinate parameter.
interface wtd_in_if #(parameter int CW = 24);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [15:0]   heading;

  modport source(output valid, cmd, pos_x, pos_y, heading, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, heading, output ready);
endinterface

FILE: rtl/wtd_out_if.sv
// Result channel interface: one turn or advance command per word.
// Depends on nothing.
interface wtd_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [24:0]        distance;
  logic signed [15:0] turn_angle;
  logic [7:0]         speed;
  logic [24:0]        duration_ms;
  logic               last;

  modport source(output valid, kind, distance, turn_angle, speed, duration_ms, last,
                 input ready);
  modport sink(input valid, kind, distance, turn_angle, speed, duration_ms, last,
               output ready);
endinterface

FILE: rtl/wtd_cfg_if.sv
// Configuration write channel interface: register index and data per word.
// Depends on nothing.
interface wtd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/wtd_sqrt.sv
// Digit-serial square root: two radicand bits per cycle, one root bit out.
// Gives the root rounded to nearest. Depends on wtd_pkg.
module wtd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wtd_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [wtd_pkg::ROOT_W:0]    root
);

  localparam int RW  = wtd_pkg::ROOT_W;
  localparam int SW  = wtd_pkg::SQ_W;
  localparam int CNW = $clog2(RW + 1);

  logic [SW-1:0]   rad_r, rad_nxt;
  logic [RW+1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CNW-1:0]  cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;

  // One restoring step: bring down two bits, try the next root bit.
  always_comb begin
    rem_sh   = {rem_r, rad_r[SW-1 -: 2]};
    trial    = (RW + 4)'({root_r, 2'b01});
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      rad_nxt = {rad_r[SW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = (RW + 2)'(rem_sh - trial);
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = (RW + 2)'(rem_sh);
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(RW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  // Round up when the remainder exceeds the root.
  assign root = ({1'b0, rem_r} > (RW + 3)'(root_r)) ? ((RW + 1)'(root_r) + 1'b1)
                                                    : (RW + 1)'(root_r);
  assign done = done_r;

endmodule

FILE: rtl/wtd_cordic.sv
// Iterative vectoring CORDIC: one rotation step per cycle gives the bearing.
// Depends on wtd_pkg for the arctangent table.
module wtd_cordic #(
  parameter int CW    = wtd_pkg::COORD_WIDTH_DEF,
  parameter int STEPS = wtd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [CW:0] dx,
  input  logic signed [CW:0] dy,
  output logic               done,
  output logic [15:0]        head
);

  localparam int XW  = CW + 27;
  localparam int NIT = (STEPS < wtd_pkg::ATAN_LEN) ? STEPS : wtd_pkg::ATAN_LEN;
  localparam int CNW = $clog2(NIT + 1);

  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys, x0, y0;
  logic [31:0]          z_r, z_nxt, z_rnd;
  logic [CNW-1:0]       cnt_r, cnt_nxt;
  logic                 run_r, run_nxt, done_r, done_nxt;

  always_comb begin
    x0       = XW'(dx) <<< 24;
    y0       = XW'(dy) <<< 24;
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      // A vector in the left half plane is turned by a half turn first.
      if (dx < 0) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = 32'h80000000;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      if (!y_r[XW-1] && (y_r != '0)) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + wtd_pkg::atan_entry(5'(cnt_r));
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - wtd_pkg::atan_entry(5'(cnt_r));
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(NIT - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // Round the 32-bit angle to 16 bits.
  assign z_rnd = z_r + 32'h00008000;
  assign head  = z_rnd[31:16];
  assign done  = done_r;

endmodule

FILE: rtl/waypoint_to_turn_drive_top.sv
// Top level of the waypoint to turn/drive converter: registers, sequencer,
// shared multiplier and result register. Depends on wtd_pkg, the channel
// interfaces, wtd_sqrt and wtd_cordic.
//
//  channel | dir | word
//  in_chan | in  | cmd, pos_x, pos_y, heading
//  out_chan| out | kind, distance, turn_angle, speed, duration_ms, last
//  cfg_chan| in  | index, data (register write)
//
// A start word or an ignored waypoint ends in S_IDLE. A processed waypoint has
// its squared lengths formed on the shared 25x25 multiplier and compared with
// the squared minimum distance (S_MA to S_CHK); one too near ends there. Then
// the square root and the CORDIC run side by side (S_RUN), the timeout is formed
// (S_MD, S_ADD), and any turn word and the advance word go out. Reset is
// synchronous and active low and sets the registers to their defaults and the
// pose to the origin. A stalled result register holds the sequencer until it frees.
module waypoint_to_turn_drive_top #(
  parameter int COORD_WIDTH  = wtd_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = wtd_pkg::CORDIC_STEPS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  wtd_in_if.sink        in_chan,
  wtd_out_if.source     out_chan,
  wtd_cfg_if.sink       cfg_chan
);

  localparam int CW  = COORD_WIDTH;
  localparam int AXW = (CW + 1 > 26) ? CW + 1 : 26;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MA   = 4'd1;
  localparam logic [3:0] S_MB   = 4'd2;
  localparam logic [3:0] S_MC   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_RUN  = 4'd5;
  localparam logic [3:0] S_MD   = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_TURN = 4'd8;
  localparam logic [3:0] S_ADV  = 4'd9;

  // Configuration registers.
  logic [15:0] min_distance_r, turn_dur_r, base_dur_r;
  logic [14:0] min_turn_r;
  logic [7:0]  turn_speed_r, adv_speed_r;
  logic [9:0]  ms_per_cm_r;
  logic [3:0]  max_wp_r;

  // Route state.
  logic signed [CW-1:0] prev_x_r, prev_y_r, px_r, py_r;
  logic [15:0]          prev_head_r;
  logic [3:0]           count_r;

  logic [3:0]                   state_r;
  logic signed [CW:0]           dx_r, dy_r;
  logic [CW:0]                  ax, ay;
  logic [AXW-1:0]               ax_w, ay_w;
  logic                         big;
  logic [wtd_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [wtd_pkg::PROD_W-1:0]   mul_r;
  logic [wtd_pkg::PROD_W:0]     sq_r;
  logic [24:0]                  dist_r;
  logic [24:0]                  dur_r;
  logic [15:0]                  diff, mag;
  logic [42:0]                  dur_sum;
  logic                         sq_start, cd_start, sq_done, cd_done;
  logic [wtd_pkg::ROOT_W:0]     root;
  logic [15:0]                  head;
  logic                         in_fire, out_free, out_load;

  logic        out_valid_r, out_kind_r, out_last_r;
  logic [24:0] out_dist_r, out_dur_r;
  logic [15:0] out_angle_r;
  logic [7:0]  out_speed_r;

  assign in_fire  = in_chan.valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;
  assign out_load = ((state_r == S_TURN) || (state_r == S_ADV)) && out_free;

  // Absolute components, widened so the 2^25 limit test fits any width.
  assign ax   = dx_r[CW] ? (CW + 1)'(-dx_r) : (CW + 1)'(dx_r);
  assign ay   = dy_r[CW] ? (CW + 1)'(-dy_r) : (CW + 1)'(dy_r);
  assign ax_w = AXW'(ax);
  assign ay_w = AXW'(ay);
  assign big  = (ax_w >= AXW'(33554432)) || (ay_w >= AXW'(33554432));

  // Shared multiplier operand select.
  always_comb begin
    mul_a = ax_w[24:0];
    mul_b = ax_w[24:0];
    unique case (state_r)
      S_MB: begin
        mul_a = ay_w[24:0];
        mul_b = ay_w[24:0];
      end
      S_MC: begin
        mul_a = 25'(min_distance_r);
        mul_b = 25'(min_distance_r);
      end
      S_MD: begin
        mul_a = dist_r;
        mul_b = 25'(ms_per_cm_r);
      end
      default: begin
        mul_a = ax_w[24:0];
        mul_b = ax_w[24:0];
      end
    endcase
  end

  // Heading change and timeout arithmetic.
  assign diff    = head - prev_head_r;
  assign mag     = diff[15] ? 16'(-diff) : diff;
  assign dur_sum = 43'(mul_r[49:8]) + 43'(base_dur_r);

  assign sq_start = (state_r == S_CHK) && !big && (sq_r > (wtd_pkg::PROD_W + 1)'(mul_r));
  assign cd_start = (state_r == S_CHK) && (big || (sq_r > (wtd_pkg::PROD_W + 1)'(mul_r)));

  wtd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({1'b0, sq_r}),
    .done     (sq_done),
    .root     (root)
  );

  wtd_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .dx    (dx_r),
    .dy    (dy_r),
    .done  (cd_done),
    .head  (head)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_distance_r <= 16'd26;
      min_turn_r     <= 15'd182;
      turn_speed_r   <= 8'd130;
      adv_speed_r    <= 8'd150;
      turn_dur_r     <= 16'd5000;
      ms_per_cm_r    <= 10'd200;
      base_dur_r     <= 16'd2000;
      max_wp_r       <= 4'd8;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        wtd_pkg::REG_MIN_DISTANCE:  min_distance_r <= cfg_chan.data;
        wtd_pkg::REG_MIN_TURN:      min_turn_r     <= cfg_chan.data[14:0];
        wtd_pkg::REG_TURN_SPEED:    turn_speed_r   <= cfg_chan.data[7:0];
        wtd_pkg::REG_ADVANCE_SPEED: adv_speed_r    <= cfg_chan.data[7:0];
        wtd_pkg::REG_TURN_DUR:      turn_dur_r     <= cfg_chan.data;
        wtd_pkg::REG_MS_PER_CM:     ms_per_cm_r    <= cfg_chan.data[9:0];
        wtd_pkg::REG_BASE_DUR:      base_dur_r     <= cfg_chan.data;
        wtd_pkg::REG_MAX_WAYPOINTS: max_wp_r       <= cfg_chan.data[3:0];
        default: ;
      endcase
    end
  end

  // Result valid: set when a word is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_head_r <= '0;
      count_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_chan.cmd == wtd_pkg::CMD_START) begin
              prev_x_r    <= in_chan.pos_x;
              prev_y_r    <= in_chan.pos_y;
              prev_head_r <= in_chan.heading;
              count_r     <= '0;
            end else if (count_r < max_wp_r) begin
              state_r <= S_MA;
            end
          end
        end
        S_MA:  state_r <= S_MB;
        S_MB:  state_r <= S_MC;
        S_MC:  state_r <= S_CHK;
        S_CHK: state_r <= cd_start ? S_RUN : S_IDLE;
        S_RUN: if (cd_done && (big || sq_done)) state_r <= S_MD;
        S_MD:  state_r <= S_ADD;
        S_ADD: state_r <= (mag > {1'b0, min_turn_r}) ? S_TURN : S_ADV;
        S_TURN: begin
          if (out_free) begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          if (out_free) begin
            prev_x_r    <= px_r;
            prev_y_r    <= py_r;
            prev_head_r <= head;
            count_r     <= count_r + 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (in_fire) begin
      px_r <= in_chan.pos_x;
      py_r <= in_chan.pos_y;
      dx_r <= (CW + 1)'(in_chan.pos_x) - (CW + 1)'(prev_x_r);
      dy_r <= (CW + 1)'(in_chan.pos_y) - (CW + 1)'(prev_y_r);
    end
    if (state_r == S_MB) sq_r <= (wtd_pkg::PROD_W + 1)'(mul_r);
    if (state_r == S_MC) sq_r <= sq_r + (wtd_pkg::PROD_W + 1)'(mul_r);
    if (state_r == S_RUN) begin
      if (big || (root > (wtd_pkg::ROOT_W + 1)'(wtd_pkg::MAX25))) dist_r <= wtd_pkg::MAX25;
      else dist_r <= root[24:0];
    end
    if (state_r == S_ADD) begin
      dur_r <= (dur_sum > 43'(wtd_pkg::MAX25)) ? wtd_pkg::MAX25 : dur_sum[24:0];
    end
    if ((state_r == S_TURN) && out_free) begin
      out_kind_r  <= wtd_pkg::KIND_TURN;
      out_dist_r  <= '0;
      out_angle_r <= diff;
      out_speed_r <= turn_speed_r;
      out_dur_r   <= 25'(turn_dur_r);
      out_last_r  <= 1'b0;
    end
    if ((state_r == S_ADV) && out_free) begin
      out_kind_r  <= wtd_pkg::KIND_ADVANCE;
      out_dist_r  <= dist_r;
      out_angle_r <= '0;
      out_speed_r <= adv_speed_r;
      out_dur_r   <= dur_r;
      out_last_r  <= 1'b1;
    end
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.distance    = out_dist_r;
  assign out_chan.turn_angle  = out_angle_r;
  assign out_chan.speed       = out_speed_r;
  assign out_chan.duration_ms = out_dur_r;
  assign out_chan.last        = out_last_r;

endmodule
